>>> sv/hkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_pkg: shared types and constants of the pair-keyed hit table
// Item and result layouts, result status codes, opcodes and table entry.
// ----------------------------------------------------------------------------
package hkt_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // Depth of the command queue between front and back end (power of two).
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned TALLY_W   = 7;

  // Opcodes of an input item.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_SWEPT    = 2'd3
  } status_e;

  typedef struct packed {
    logic               opcode;
    logic [ADDR_W-1:0]  bssid;
    logic [ADDR_W-1:0]  client;
    logic [STAMP_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  entry_slot;
    logic [COUNT_W-1:0] hit_count;
    logic [TALLY_W-1:0] removed_count;
    logic [TALLY_W-1:0] entries_in_use;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic               is_sweep;
    logic [ADDR_W-1:0]  bssid;
    logic [ADDR_W-1:0]  client;
    logic [STAMP_W-1:0] now;
  } cmd_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  key_first;
    logic [ADDR_W-1:0]  key_second;
    logic [STAMP_W-1:0] last_seen;
    logic [COUNT_W-1:0] hit_total;
  } entry_t;

endpackage

>>> sv/hkt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_front: item intake and command queue
// Accepts items, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
module hkt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hkt_pkg::in_item_t item_i,
  output logic              busy_o,
  input  logic              pop_i,
  output logic              cmd_valid_o,
  output hkt_pkg::cmd_t     cmd_o
);
  import hkt_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;
  cmd_t            cmd_new;

  // The queue is full: no more items are taken.
  assign busy_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Classify the item into a command.
  always_comb begin
    cmd_new.is_sweep = (item_i.opcode == OP_SWEEP);
    cmd_new.bssid    = item_i.bssid;
    cmd_new.client   = item_i.client;
    cmd_new.now      = item_i.now;
  end

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> sv/hkt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_engine: table walk engine
// Holds the entry memory and runs the record search and the aging sweep.
// ----------------------------------------------------------------------------
module hkt_engine #(
  parameter int unsigned TableDepth = hkt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  hkt_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  input  logic [hkt_pkg::STAMP_W-1:0] age_limit_i,
  output logic                       result_valid_o,
  output hkt_pkg::out_item_t         result_o
);
  import hkt_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned FillW = $clog2(TableDepth + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_HIT     = 3'd2;
  localparam logic [2:0] S_MISS    = 3'd3;
  localparam logic [2:0] S_SW_RD   = 3'd4;
  localparam logic [2:0] S_SW_CHK  = 3'd5;
  localparam logic [2:0] S_SW_MOVE = 3'd6;

  logic [2:0]         state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   idx_q, idx_d;
  logic [FillW-1:0]   removed_q, removed_d;
  logic               pend_q, pend_d;
  logic [IdxW-1:0]    pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]    hit_idx_q, hit_idx_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               res_valid_q, res_valid_d;
  out_item_t          res_q, res_d;

  entry_t             table_q [TableDepth];
  entry_t             rdata_q;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  entry_t             wr_data;

  logic               key_match;
  logic               expired;
  logic [STAMP_W:0]   expiry;
  logic [FillW-1:0]   idx_next;
  logic [FillW-1:0]   fill_dec;
  logic [COUNT_W-1:0] cnt_inc;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Compare and aging terms on the registered read data.
  assign key_match = (rdata_q.key_first == cmd_q.bssid) &&
                     (rdata_q.key_second == cmd_q.client);
  assign expiry    = {1'b0, rdata_q.last_seen} + {1'b0, age_limit_i};
  assign expired   = (expiry < {1'b0, cmd_q.now});
  assign idx_next  = idx_q + FillW'(1);
  assign fill_dec  = fill_q - FillW'(1);
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_W'(1);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    removed_d   = removed_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_idx_d   = hit_idx_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[IdxW-1:0];
    wr_data     = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o     = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          removed_d = '0;
          pend_d    = 1'b0;
          state_d   = cmd_i.is_sweep ? S_SW_RD : S_SEARCH;
        end
      end

      // Reads stream one slot a cycle; each compare sees the previous read.
      S_SEARCH: begin
        if (pend_q && key_match) begin
          hit_idx_d = pend_idx_q;
          cnt_d     = rdata_q.hit_total;
          pend_d    = 1'b0;
          state_d   = S_HIT;
        end else if (idx_q < fill_q) begin
          rd_en      = 1'b1;
          rd_addr    = idx_q[IdxW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IdxW-1:0];
          idx_d      = idx_next;
        end else begin
          pend_d  = 1'b0;
          state_d = S_MISS;
        end
      end

      // Refresh the stamp and bump the saturating count.
      S_HIT: begin
        wr_en                    = 1'b1;
        wr_addr                  = hit_idx_q;
        wr_data.key_first        = cmd_q.bssid;
        wr_data.key_second       = cmd_q.client;
        wr_data.last_seen        = cmd_q.now;
        wr_data.hit_total        = cnt_inc;
        res_valid_d              = 1'b1;
        res_d.status             = ST_UPDATED;
        res_d.entry_slot         = SLOT_W'(hit_idx_q);
        res_d.hit_count          = cnt_inc;
        res_d.removed_count      = '0;
        res_d.entries_in_use     = TALLY_W'(fill_q);
        state_d                  = S_IDLE;
      end

      // Append a new entry, or drop the request when the table is full.
      S_MISS: begin
        res_valid_d          = 1'b1;
        res_d.removed_count  = '0;
        if (fill_q != FillW'(TableDepth)) begin
          wr_en                = 1'b1;
          wr_addr              = fill_q[IdxW-1:0];
          wr_data.key_first    = cmd_q.bssid;
          wr_data.key_second   = cmd_q.client;
          wr_data.last_seen    = cmd_q.now;
          wr_data.hit_total    = COUNT_W'(1);
          fill_d               = fill_q + FillW'(1);
          res_d.status         = ST_INSERTED;
          res_d.entry_slot     = SLOT_W'(fill_q);
          res_d.hit_count      = COUNT_W'(1);
          res_d.entries_in_use = TALLY_W'(fill_q + FillW'(1));
        end else begin
          res_d.status         = ST_FULL;
          res_d.entry_slot     = '0;
          res_d.hit_count      = '0;
          res_d.entries_in_use = TALLY_W'(fill_q);
        end
        state_d = S_IDLE;
      end

      // Start the sweep, or finish it on an empty table.
      S_SW_RD: begin
        if (idx_q < fill_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IdxW-1:0];
          state_d = S_SW_CHK;
        end else begin
          res_valid_d          = 1'b1;
          res_d.status         = ST_SWEPT;
          res_d.entry_slot     = '0;
          res_d.hit_count      = '0;
          res_d.removed_count  = TALLY_W'(removed_q);
          res_d.entries_in_use = TALLY_W'(fill_q);
          state_d              = S_IDLE;
        end
      end

      // Check the entry at the current slot.
      S_SW_CHK: begin
        if (!expired) begin
          idx_d = idx_next;
          if (idx_next < fill_q) begin
            rd_en   = 1'b1;
            rd_addr = idx_next[IdxW-1:0];
          end else begin
            res_valid_d          = 1'b1;
            res_d.status         = ST_SWEPT;
            res_d.entry_slot     = '0;
            res_d.hit_count      = '0;
            res_d.removed_count  = TALLY_W'(removed_q);
            res_d.entries_in_use = TALLY_W'(fill_q);
            state_d              = S_IDLE;
          end
        end else begin
          fill_d    = fill_dec;
          removed_d = removed_q + FillW'(1);
          if (idx_q == fill_dec) begin
            // The last entry expired: the walk is over.
            res_valid_d          = 1'b1;
            res_d.status         = ST_SWEPT;
            res_d.entry_slot     = '0;
            res_d.hit_count      = '0;
            res_d.removed_count  = TALLY_W'(removed_q + FillW'(1));
            res_d.entries_in_use = TALLY_W'(fill_dec);
            state_d              = S_IDLE;
          end else begin
            // Fetch the last entry to fill the hole.
            rd_en   = 1'b1;
            rd_addr = fill_dec[IdxW-1:0];
            state_d = S_SW_MOVE;
          end
        end
      end

      // Move the last entry into the hole; read data holds for the recheck.
      S_SW_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IdxW-1:0];
        wr_data = rdata_q;
        state_d = S_SW_CHK;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    removed_q  <= removed_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
  end

  // Entry memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= table_q[rd_addr];
    end
  end

endmodule

>>> sv/pair_keyed_hit_table_with_aging_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_keyed_hit_table_with_aging_top: pair-keyed hit table with aging
// Exact-match table keyed by two 48-bit addresses with hit counts, stamps
// and an aging sweep that compacts the table.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ----------------------------
//   item in   start_i && !busy_o           item_i (in_item_t)
//   result    result_valid_o, one cycle    result_o (out_item_t)
//   config    cfg_valid_i && cfg_ready_o   cfg_data_i (age limit)
//
// A record walks the filled slots through the read port of the entry memory,
// which reads one slot a cycle. A sweep walks the filled slots as well, and
// each removal adds a write of the moved entry into the hole.
// Two commands queue ahead of the engine; busy_o rises when both are held.
// Reset empties the table at once; no clearing pass is needed.
// Results cannot be stalled and appear for exactly one cycle.
// ----------------------------------------------------------------------------
module pair_keyed_hit_table_with_aging_top #(
  parameter int unsigned TableDepth = hkt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  hkt_pkg::in_item_t           item_i,
  output logic                        busy_o,
  output logic                        result_valid_o,
  output hkt_pkg::out_item_t          result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hkt_pkg::STAMP_W-1:0] cfg_data_i
);
  import hkt_pkg::*;

  logic               cmd_valid;
  logic               cmd_pop;
  cmd_t               cmd;
  logic [STAMP_W-1:0] age_limit_q;

  // The age limit register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      age_limit_q <= cfg_data_i;
    end
  end

  // Intake and command queue.
  hkt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .pop_i       (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // Table engine.
  hkt_engine #(
    .TableDepth (TableDepth)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .pop_o          (cmd_pop),
    .age_limit_i    (age_limit_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> sv/hkt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_checker: port-level checks of the hit table
// Watches the top-level ports and flags inconsistent result items.
// ----------------------------------------------------------------------------
module hkt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               result_valid_o,
  input hkt_pkg::out_item_t result_o
);
  import hkt_pkg::*;

  // Every item needs at least a pop and a walk step, so results never
  // come in adjacent cycles.
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results in back-to-back cycles");

  // A sweep reports no slot and no count.
  a_sweep_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_SWEPT) |->
      (result_o.entry_slot == '0 && result_o.hit_count == '0))
    else $error("sweep result carries slot or count");

  // Only a sweep removes entries.
  a_record_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_SWEPT) |->
      (result_o.removed_count == '0))
    else $error("record result reports removals");

  // A fresh entry starts with a count of one and a nonzero fill.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_INSERTED) |->
      (result_o.hit_count == COUNT_W'(1) && result_o.entries_in_use != '0))
    else $error("inserted entry has wrong count or fill");

endmodule

bind pair_keyed_hit_table_with_aging_top hkt_checker u_hkt_checker (.*);
